// ===== design/sha_pkg.sv =====
// shared types, constants and a rotate helper for the sha-256 stream hasher
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // one queued request from the front to the core
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } req_t;

  localparam int QueueDepth = 4;
  localparam int QueueAw = $clog2(QueueDepth);

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [63:0] BlockBits = 64'd512;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== design/sha_front.sv =====
// input classifier and request queue between the port and the core
module sha_front (
  input  logic             clk,
  input  logic             rst,
  input  sha_pkg::in_item_t in_data,
  input  logic             in_valid,
  output logic             in_stall,
  output sha_pkg::req_t    req,
  output logic             req_valid,
  input  logic             req_take
);
  import sha_pkg::*;

  req_t              slots [QueueDepth];
  logic [QueueAw-1:0] rd_ptr, wr_ptr;
  logic [QueueAw:0]   count;
  logic               push, pop;

  // idle items change nothing, so they are dropped here
  assign in_stall = (count == (QueueAw+1)'(QueueDepth));
  assign push = in_valid && !in_stall && (in_data.byte_valid || in_data.end_of_message);
  assign pop = req_valid && req_take;
  assign req_valid = (count != '0);
  assign req = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].data_byte <= in_data.data_byte;
      slots[wr_ptr].byte_valid <= in_data.byte_valid;
      slots[wr_ptr].end_of_message <= in_data.end_of_message;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == (QueueAw+1)'(QueueDepth)) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !pop) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1)) else $error("count step");
`endif

endmodule

// ===== design/sha_core.sv =====
// block buffer, padding sequencer, one-round-per-cycle compression and digest output
module sha_core (
  input  logic              clk,
  input  logic              rst,
  input  sha_pkg::req_t     req,
  input  logic              req_valid,
  output logic              req_take,
  output sha_pkg::out_item_t out_data,
  output logic              out_valid,
  input  logic              out_stall
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_ROUND, S_ADD, S_EMIT
  } state_t;

  state_t      state;
  logic [31:0] w [16];
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [3:0]  fill_word;
  logic [1:0]  fill_byte;
  logic [5:0]  round;
  logic [63:0] bit_count;
  logic        final_blk;   // block being compressed ends the message
  logic        pad_done;    // 0x80 already placed
  logic        pad_pend;    // another padding sweep follows this compression
  logic [5:0]  pad_pos;
  logic [2:0]  emit_idx;

  logic [31:0] wt, w_new, s0, s1, t1, t2, big0, big1, ch, maj;
  logic [31:0] cur_word;
  logic [5:0]  fill;

  assign fill = {fill_word, fill_byte};
  assign cur_word = w[fill_word];

  // schedule word for this round, computed on a 16-entry rolling window
  assign s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
  assign s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
  assign w_new = s1 + w[9] + s0 + w[0];
  assign wt = w[0];

  // round function
  assign big1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
  assign ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1 = v[7] + big1 + ch + RoundK[round] + wt;
  assign big0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2 = big0 + maj;

  assign req_take = (state == S_IDLE) && req_valid;
  assign out_valid = (state == S_EMIT);
  assign out_data.digest_word = h[emit_idx];
  assign out_data.word_index = emit_idx;
  assign out_data.last_word = (emit_idx == 3'd7);

  function automatic logic [31:0] put_byte(input logic [31:0] wd, input logic [1:0] pos,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = wd;
    r[8*(3-pos) +: 8] = b;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill_word <= '0;
      fill_byte <= '0;
      bit_count <= '0;
      final_blk <= 1'b0;
      pad_done <= 1'b0;
      pad_pend <= 1'b0;
      emit_idx <= '0;
      round <= '0;
      for (int i = 0; i < 8; i++) h[i] <= InitH[i];
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.byte_valid) begin
              w[fill_word] <= put_byte(cur_word, fill_byte, req.data_byte);
              {fill_word, fill_byte} <= fill + 6'd1;
              if (fill == 6'd63) begin
                bit_count <= bit_count + BlockBits;
                final_blk <= 1'b0;
                pad_done <= 1'b0;
                for (int i = 0; i < 8; i++) v[i] <= h[i];
                round <= '0;
                state <= S_ROUND;
                // end with a full block: padding starts after this compression
                pad_pend <= req.end_of_message;
              end else if (req.end_of_message) begin
                bit_count <= bit_count + {55'd0, fill + 6'd1, 3'd0};
                pad_pos <= fill + 6'd1;
                state <= S_PAD;
              end
            end else begin
              bit_count <= bit_count + {55'd0, fill, 3'd0};
              pad_pos <= fill;
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // one padding byte per cycle
          if (!pad_done) begin
            w[pad_pos[5:2]] <= put_byte(w[pad_pos[5:2]], pad_pos[1:0], PadByte);
            pad_done <= 1'b1;
          end else if (pad_pos >= LenStart) begin
            w[pad_pos[5:2]] <= put_byte(w[pad_pos[5:2]], pad_pos[1:0], 8'h00);
          end else begin
            w[pad_pos[5:2]] <= put_byte(w[pad_pos[5:2]], pad_pos[1:0], 8'h00);
          end
          pad_pos <= pad_pos + 6'd1;
          if (pad_pos == 6'd55) begin
            w[14] <= bit_count[63:32];
            w[15] <= bit_count[31:0];
            final_blk <= 1'b1;
            for (int i = 0; i < 8; i++) v[i] <= h[i];
            round <= '0;
            state <= S_ROUND;
          end else if (pad_pos == 6'd63) begin
            // no room for the length: a second padding block follows
            final_blk <= 1'b0;
            pad_pend <= 1'b1;
            for (int i = 0; i < 8; i++) v[i] <= h[i];
            round <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          fill_word <= '0;
          fill_byte <= '0;
          if (final_blk) begin
            emit_idx <= '0;
            state <= S_EMIT;
          end else if (pad_pend) begin
            pad_pos <= '0;
            pad_pend <= 1'b0;
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) h[i] <= InitH[i];
              bit_count <= '0;
              pad_done <= 1'b0;
              pad_pend <= 1'b0;
              final_blk <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    req_take |-> (state == S_IDLE)) else $error("take outside idle");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && emit_idx == $past(emit_idx)))
    else $error("emit index moved under stall");
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round == 6'd63) |=> (state == S_ADD)) else $error("round count");
  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.last_word) |=> (state == S_IDLE && bit_count == '0))
    else $error("no restart after digest");
`endif

endmodule

// ===== design/sha256_stream_hasher_top.sv =====
// top level of the sha-256 stream hasher
// One message byte per request; after a 64-byte block the core runs the one-round-per-cycle
// compression (64 rounds, then one chaining add) and takes no requests until it is done. The
// end request costs a padding sweep of one byte per cycle up to the length field (or to the
// block end and again from the start of a second block), one or two compressions, then eight
// digest words, word 0 first.
// A four-entry queue in front lets the port keep taking requests while the core is busy.
// Idle requests are dropped. After the last digest word the hasher restarts at the initial value.
module sha256_stream_hasher_top (
  input  logic               clk,
  input  logic               rst,
  input  sha_pkg::in_item_t  in_data,
  input  logic               in_valid,
  output logic               in_stall,
  output sha_pkg::out_item_t out_data,
  output logic               out_valid,
  input  logic               out_stall
);
  import sha_pkg::*;

  req_t req;
  logic req_valid, req_take;

  sha_front u_front (
    .clk(clk), .rst(rst), .in_data(in_data), .in_valid(in_valid), .in_stall(in_stall),
    .req(req), .req_valid(req_valid), .req_take(req_take)
  );

  sha_core u_core (
    .clk(clk), .rst(rst), .req(req), .req_valid(req_valid), .req_take(req_take),
    .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
  );

endmodule

// ===== sim/sha256_stream_hasher_top_tb.sv =====
// testbench for the sha-256 stream hasher: digest prediction, random idling and backpressure
module sha256_stream_hasher_top_tb;
  import sha_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  in_item_t in_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  out_item_t out_data;
  logic out_valid;
  logic out_stall = 1'b0;

  // digest predictor state
  logic [31:0] hash_state [8];
  logic [7:0] msg_block [64];
  int unsigned block_bytes;
  logic [63:0] total_bits;
  out_item_t digest_queue [$];

  int errors = 0;
  int words_checked = 0;
  int messages_sent = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_off = 0;
  bit random_stall = 1'b1;

  sha256_stream_hasher_top u_dut (
    .clk(clk), .rst(rst), .in_data(in_data), .in_valid(in_valid), .in_stall(in_stall),
    .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
  );

  always #6 clk = ~clk;

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of msg_block into hash_state
  function automatic void compress_into_state();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int t = 0; t < 8; t++) v[t] = hash_state[t];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int t = 0; t < 8; t++) hash_state[t] = hash_state[t] + v[t];
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = InitH[i];
    block_bytes = 0;
    total_bits = '0;
  endfunction

  // advance the predictor by one accepted request
  function automatic void predict_digest(in_item_t req);
    int unsigned i;
    out_item_t word;
    if (req.byte_valid) begin
      msg_block[block_bytes] = req.data_byte;
      block_bytes++;
      if (block_bytes == 64) begin
        compress_into_state();
        total_bits += BlockBits;
        block_bytes = 0;
      end
    end
    if (!req.end_of_message) return;
    i = block_bytes;
    total_bits += 64'(i) * 8;
    msg_block[i++] = PadByte;
    if (i > 56) begin
      while (i < 64) msg_block[i++] = 8'h00;
      compress_into_state();
      i = 0;
    end
    while (i < 56) msg_block[i++] = 8'h00;
    for (int k = 0; k < 8; k++) msg_block[56+k] = total_bits[63-8*k -: 8];
    compress_into_state();
    for (int k = 0; k < 8; k++) begin
      word.digest_word = hash_state[k];
      word.word_index = 3'(k);
      word.last_word = (k == 7);
      digest_queue.push_back(word);
    end
    restart_hash();
  endfunction

  // receiver stall pattern, with a long hold-off when requested
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (random_stall) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t exp_word;
    if (!rst && out_valid && !out_stall) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest word, actual %h", $time, out_data);
        errors++;
      end else begin
        exp_word = digest_queue.pop_front();
        words_checked++;
        if (out_data.digest_word !== exp_word.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $time,
                   exp_word.digest_word, out_data.digest_word);
          errors++;
        end
        if (out_data.word_index !== exp_word.word_index) begin
          $display("%0t: word_index expected %0d actual %0d", $time,
                   exp_word.word_index, out_data.word_index);
          errors++;
        end
        if (out_data.last_word !== exp_word.last_word) begin
          $display("%0t: last_word expected %0d actual %0d", $time,
                   exp_word.last_word, out_data.last_word);
          errors++;
        end
      end
    end
  end

  // offer one request, with optional bursty gaps, and hold it until accepted
  task automatic send_request(logic [7:0] b, logic v, logic e, bit gaps = 1'b1);
    in_item_t req;
    int unsigned gap;
    req.data_byte = b;
    req.byte_valid = v;
    req.end_of_message = e;
    if (gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_digest(req);
    if (e) messages_sent++;
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_digests();
    idle_sender();
    while (digest_queue.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_message(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      if (i + 1 == len && $urandom_range(0, 1)) begin
        send_request(8'($urandom), 1'b1, 1'b1);
        return;
      end
      send_request(8'($urandom), 1'b1, 1'b0);
    end
    send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // empty message, a three-byte message, single bytes with byte extremes, an idle request
  task automatic test_short_messages();
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    wait_for_digests();
  endtask

  // padding boundaries: 55 bytes fill one block exactly, 64 bytes end on a full block
  task automatic test_padding_boundaries();
    for (int i = 0; i < 54; i++) send_request(8'($urandom), 1'b1, 1'b0);
    send_request(8'ha5, 1'b1, 1'b1);
    for (int i = 0; i < 63; i++) send_request(8'($urandom), 1'b1, 1'b0);
    send_request(8'h5a, 1'b1, 1'b1);
    wait_for_digests();
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 400;
    for (int m = 0; m < 2; m++) begin
      for (int i = 0; i < 3; i++) send_request(8'($urandom), 1'b1, 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, 1'b1, 1'b0);
    end
    wait_for_digests();
  endtask

  // random short messages with idle requests mixed in
  task automatic test_random_messages();
    int unsigned len;
    for (int m = 0; m < 3; m++) begin
      random_stall = (m != 2);
      len = $urandom_range(0, 6);
      send_random_message(len);
    end
    random_stall = 1'b1;
    wait_for_digests();
  endtask

  initial begin
    restart_hash();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_messages();
    test_padding_boundaries();
    test_backpressure();
    test_random_messages();
    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d messages (empty, single byte, padding edges, multi-block)", messages_sent);
    $display("checked %0d digest words under random stalls and a long receiver hold-off",
             words_checked);
    if (errors == 0 && digest_queue.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
